FILE: rtl/rtb_pkg.sv
// Types, constants and the macro-period table for the ranging timing budget calculator.
// Depends on nothing; used by ranging_timing_budget_calc and its testbench.
`default_nettype none
package rtb_pkg;

  localparam int unsigned MACRO_W   = 20;
  localparam int unsigned US_W      = 23;
  localparam int unsigned DIV_STAGES = 32;
  localparam int unsigned LATENCY   = 7 + DIV_STAGES + 1;

  localparam longint unsigned MACRO_VCLKS   = 2304;
  localparam longint unsigned PLL_TICK_PS   = 1655;
  localparam longint unsigned NS_PER_US     = 1000;

  localparam logic [31:0] GET_START_OH = 32'd1910;
  localparam logic [31:0] SET_START_OH = 32'd1320;
  localparam logic [31:0] END_OH       = 32'd960;
  localparam logic [31:0] MSRC_OH      = 32'd660;
  localparam logic [31:0] TCC_OH       = 32'd590;
  localparam logic [31:0] DSS_OH       = 32'd690;
  localparam logic [31:0] PRE_OH       = 32'd660;
  localparam logic [31:0] FINAL_OH     = 32'd550;
  localparam logic [31:0] MIN_TOTAL_US = 32'd20000;
  localparam logic [31:0] US_SCALE     = 32'd1000;

  // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BELOW_MIN = 2'd1;
  localparam logic [1:0] ST_OVERHEAD  = 2'd2;
  localparam logic [1:0] ST_ZERO_PER  = 2'd3;

  localparam int unsigned SEQ_TCC   = 4;
  localparam int unsigned SEQ_DSS   = 3;
  localparam int unsigned SEQ_MSRC  = 2;
  localparam int unsigned SEQ_PRE   = 6;
  localparam int unsigned SEQ_FINAL = 7;

  typedef struct packed {
    logic        mode;
    logic [7:0]  sequence_enables;
    logic [7:0]  pre_period_code;
    logic [7:0]  final_period_code;
    logic [7:0]  msrc_timeout_code;
    logic [15:0] pre_timeout_code;
    logic [15:0] final_timeout_code_in;
    logic [31:0] req_total_us;
  } in_t;

  typedef struct packed {
    logic [31:0] total_us;
    logic [15:0] final_timeout_code_out;
    logic        code_valid;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic               mode;
    logic               tcc;
    logic               dss;
    logic               msrc;
    logic               pre;
    logic               fin;
    logic [31:0]        req;
    logic [15:0]        pre_clk;
    logic [MACRO_W-1:0] fin_macro;
    logic [MACRO_W-1:0] pre_macro;
  } ctx_t;

  typedef struct packed {
    logic               pre;
    logic [15:0]        pre_clk;
    logic [MACRO_W-1:0] divisor;
    logic [31:0]        budget;
    logic [1:0]         status;
    logic               need_div;
  } dctx_t;

  typedef logic [MACRO_W-1:0] macro_lut_t [256];

  function automatic macro_lut_t build_macro_lut();
    macro_lut_t      lut;
    longint unsigned p;
    for (int i = 0; i < 256; i++) begin
      p = ((longint'(i) + 1) * 2) % 256;
      lut[i] = MACRO_W'((MACRO_VCLKS * p * PLL_TICK_PS + 500) / NS_PER_US);
    end
    return lut;
  endfunction

  localparam macro_lut_t MACRO_LUT = build_macro_lut();

  function automatic logic [15:0] decode_clocks(input logic [15:0] code);
    logic [15:0] v;
    v = (code[15:8] < 8'd16) ? (16'(code[7:0]) << code[11:8]) : 16'd0;
    return v + 16'd1;
  endfunction

  function automatic logic [15:0] encode_clocks(input logic [15:0] clocks);
    logic [15:0] ls;
    logic [3:0]  hi;
    logic [3:0]  ms;
    ls = clocks - 16'd1;
    hi = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (ls[i]) hi = 4'(i);
    end
    ms = (hi > 4'd7) ? hi - 4'd7 : 4'd0;
    if (clocks == 16'd0) return 16'd0;
    return {4'd0, ms, 8'(ls >> ms)};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ranging_timing_budget_calc.sv
// Ranging timing budget calculator, top level: fully pipelined datapath.
// Depends on rtb_pkg.
`default_nettype none
// Usage:
//   Drive an item on in_data and pulse start; a transfer happens at each
//   rising edge with start high and busy low. busy is always low, so one
//   item may enter every cycle.
//   Each result appears on out_data for one cycle with out_valid high,
//   in the order of the input transfers. Throughput: one item per cycle.
//   Most of the pipeline is the 32-stage restoring divider that turns the
//   remaining time into final-range macro clocks; seven stages ahead of
//   it handle the period table, the step-time multiplies, the divide by
//   1000 and the budget sums.
//   The receiver cannot stall: results are shown once and must be taken.
//   Reset (rst_n low, synchronous) clears every valid bit; items in flight
//   are dropped and no result is shown until a new transfer.
module ranging_timing_budget_calc (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire rtb_pkg::in_t in_data,
  output logic              out_valid,
  output rtb_pkg::out_t     out_data
);

  localparam int unsigned MW = rtb_pkg::MACRO_W;
  localparam int unsigned DS = rtb_pkg::DIV_STAGES;

  assign busy = 1'b0;

  logic [6:0] v_r;

  // stage A
  rtb_pkg::ctx_t a_ctx_r, a_ctx_nxt;
  logic [15:0]   a_fin_clk_r, a_fin_clk_nxt;
  logic [8:0]    a_msrc_clk_r;
  // stage B
  rtb_pkg::ctx_t b_ctx_r;
  logic [31:0]   b_msrc_r, b_pre_r, b_fin_r;
  // stage C
  rtb_pkg::ctx_t c_ctx_r;
  logic [31:0]   c_msrc_r, c_pre_r, c_fin_r;
  // stage D
  rtb_pkg::ctx_t d_ctx_r;
  logic [rtb_pkg::US_W-1:0] d_msrc_r, d_pre_r, d_fin_r;
  logic [60:0]   d_pm, d_pp, d_pf;
  // stage E
  rtb_pkg::ctx_t e_ctx_r;
  logic [31:0]   e_used_r, e_used_nxt;
  logic [rtb_pkg::US_W-1:0] e_fin_r;
  // stage F
  rtb_pkg::dctx_t f_ctx_r, f_ctx_nxt;
  logic [31:0]    f_left_r, f_left_nxt;
  logic [31:0]    f_used1;
  // stage G
  rtb_pkg::dctx_t g_ctx_r;
  logic [31:0]    g_num_r;
  logic [31:0]    g_prod;
  // divider
  logic [DS-1:0]    dv_r;
  rtb_pkg::dctx_t   dctx_r [DS];
  logic [MW-1:0]    drem_r [DS];
  logic [MW-1:0]    drem_nxt [DS];
  logic [31:0]      dnum_r [DS];
  logic [15:0]      dquo_r [DS];
  logic [15:0]      dquo_nxt [DS];
  // output
  rtb_pkg::out_t  out_nxt;
  logic [15:0]    o_clk;

  always_comb begin
    a_ctx_nxt.mode      = in_data.mode;
    a_ctx_nxt.tcc       = in_data.sequence_enables[rtb_pkg::SEQ_TCC];
    a_ctx_nxt.dss       = in_data.sequence_enables[rtb_pkg::SEQ_DSS];
    a_ctx_nxt.msrc      = in_data.sequence_enables[rtb_pkg::SEQ_MSRC];
    a_ctx_nxt.pre       = in_data.sequence_enables[rtb_pkg::SEQ_PRE];
    a_ctx_nxt.fin       = in_data.sequence_enables[rtb_pkg::SEQ_FINAL];
    a_ctx_nxt.req       = in_data.req_total_us;
    a_ctx_nxt.pre_clk   = rtb_pkg::decode_clocks(in_data.pre_timeout_code);
    a_ctx_nxt.fin_macro = rtb_pkg::MACRO_LUT[in_data.final_period_code];
    a_ctx_nxt.pre_macro = rtb_pkg::MACRO_LUT[in_data.pre_period_code];
    a_fin_clk_nxt = rtb_pkg::decode_clocks(in_data.final_timeout_code_in);
    if (a_ctx_nxt.pre) begin
      a_fin_clk_nxt = a_fin_clk_nxt - a_ctx_nxt.pre_clk;
    end
  end

  always_comb begin
    d_pm = 61'(c_msrc_r) * 61'(rtb_pkg::RECIP_1000);
    d_pp = 61'(c_pre_r) * 61'(rtb_pkg::RECIP_1000);
    d_pf = 61'(c_fin_r) * 61'(rtb_pkg::RECIP_1000);
  end

  always_comb begin
    e_used_nxt = (d_ctx_r.mode ? rtb_pkg::SET_START_OH : rtb_pkg::GET_START_OH)
                 + rtb_pkg::END_OH;
    if (d_ctx_r.tcc) begin
      e_used_nxt = e_used_nxt + 32'(d_msrc_r) + rtb_pkg::TCC_OH;
    end
    if (d_ctx_r.dss) begin
      e_used_nxt = e_used_nxt + ((32'(d_msrc_r) + rtb_pkg::DSS_OH) << 1);
    end else if (d_ctx_r.msrc) begin
      e_used_nxt = e_used_nxt + 32'(d_msrc_r) + rtb_pkg::MSRC_OH;
    end
    if (d_ctx_r.pre) begin
      e_used_nxt = e_used_nxt + 32'(d_pre_r) + rtb_pkg::PRE_OH;
    end
  end

  always_comb begin
    f_used1            = e_used_r + rtb_pkg::FINAL_OH;
    f_left_nxt         = e_ctx_r.req - f_used1;
    f_ctx_nxt.pre      = e_ctx_r.pre;
    f_ctx_nxt.pre_clk  = e_ctx_r.pre_clk;
    f_ctx_nxt.divisor  = e_ctx_r.fin_macro;
    f_ctx_nxt.budget   = 32'd0;
    f_ctx_nxt.status   = rtb_pkg::ST_OK;
    f_ctx_nxt.need_div = 1'b0;
    if (!e_ctx_r.mode) begin
      f_ctx_nxt.budget = e_ctx_r.fin ? f_used1 + 32'(e_fin_r) : e_used_r;
    end else if (e_ctx_r.req < rtb_pkg::MIN_TOTAL_US) begin
      f_ctx_nxt.status = rtb_pkg::ST_BELOW_MIN;
    end else if (!e_ctx_r.fin) begin
      f_ctx_nxt.budget = e_ctx_r.req;
    end else if (f_used1 > e_ctx_r.req) begin
      f_ctx_nxt.status = rtb_pkg::ST_OVERHEAD;
    end else if (e_ctx_r.fin_macro == '0) begin
      f_ctx_nxt.status = rtb_pkg::ST_ZERO_PER;
    end else begin
      f_ctx_nxt.budget   = e_ctx_r.req;
      f_ctx_nxt.need_div = 1'b1;
    end
  end

  assign g_prod = f_left_r * rtb_pkg::US_SCALE;

  // restoring divider, one quotient bit per stage
  always_comb begin
    logic [MW:0] sh;
    logic [MW:0] df;
    logic [MW-1:0] rem_in;
    logic [31:0]   num_in;
    logic [15:0]   quo_in;
    logic [MW-1:0] dvs;
    for (int k = 0; k < DS; k++) begin
      rem_in = (k == 0) ? '0 : drem_r[(k == 0) ? 0 : k-1];
      num_in = (k == 0) ? g_num_r : (dnum_r[(k == 0) ? 0 : k-1] << 1);
      quo_in = (k == 0) ? 16'd0 : dquo_r[(k == 0) ? 0 : k-1];
      dvs    = (k == 0) ? g_ctx_r.divisor : dctx_r[(k == 0) ? 0 : k-1].divisor;
      sh = {rem_in, num_in[31]};
      df = sh - {1'b0, dvs};
      if (sh >= {1'b0, dvs}) begin
        drem_nxt[k] = df[MW-1:0];
        dquo_nxt[k] = {quo_in[14:0], 1'b1};
      end else begin
        drem_nxt[k] = sh[MW-1:0];
        dquo_nxt[k] = {quo_in[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    o_clk = dquo_r[DS-1] + (dctx_r[DS-1].pre ? dctx_r[DS-1].pre_clk : 16'd0);
    out_nxt.total_us               = dctx_r[DS-1].budget;
    out_nxt.status                 = dctx_r[DS-1].status;
    out_nxt.code_valid             = dctx_r[DS-1].need_div;
    out_nxt.final_timeout_code_out =
      dctx_r[DS-1].need_div ? rtb_pkg::encode_clocks(o_clk) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      dv_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      v_r       <= {v_r[5:0], start & ~busy};
      dv_r      <= {dv_r[DS-2:0], v_r[6]};
      out_valid <= dv_r[DS-1];
    end
  end

  always_ff @(posedge clk) begin
    a_ctx_r      <= a_ctx_nxt;
    a_fin_clk_r  <= a_fin_clk_nxt;
    a_msrc_clk_r <= 9'(in_data.msrc_timeout_code) + 9'd1;

    b_ctx_r  <= a_ctx_r;
    b_msrc_r <= 32'(29'(a_msrc_clk_r) * 29'(a_ctx_r.pre_macro));
    b_pre_r  <= 32'(36'(a_ctx_r.pre_clk) * 36'(a_ctx_r.pre_macro));
    b_fin_r  <= 32'(36'(a_fin_clk_r) * 36'(a_ctx_r.fin_macro));

    c_ctx_r  <= b_ctx_r;
    c_msrc_r <= b_msrc_r + 32'(b_ctx_r.pre_macro >> 1);
    c_pre_r  <= b_pre_r + 32'(b_ctx_r.pre_macro >> 1);
    c_fin_r  <= b_fin_r + 32'(b_ctx_r.fin_macro >> 1);

    d_ctx_r  <= c_ctx_r;
    d_msrc_r <= d_pm[rtb_pkg::RECIP_SHIFT +: rtb_pkg::US_W];
    d_pre_r  <= d_pp[rtb_pkg::RECIP_SHIFT +: rtb_pkg::US_W];
    d_fin_r  <= d_pf[rtb_pkg::RECIP_SHIFT +: rtb_pkg::US_W];

    e_ctx_r  <= d_ctx_r;
    e_used_r <= e_used_nxt;
    e_fin_r  <= d_fin_r;

    f_ctx_r  <= f_ctx_nxt;
    f_left_r <= f_left_nxt;

    g_ctx_r <= f_ctx_r;
    g_num_r <= g_prod + 32'(f_ctx_r.divisor >> 1);

    for (int k = 0; k < DS; k++) begin
      drem_r[k] <= drem_nxt[k];
      dquo_r[k] <= dquo_nxt[k];
      dnum_r[k] <= (k == 0) ? g_num_r : (dnum_r[(k == 0) ? 0 : k-1] << 1);
      dctx_r[k] <= (k == 0) ? g_ctx_r : dctx_r[(k == 0) ? 0 : k-1];
    end

    out_data <= out_nxt;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(rtb_pkg::LATENCY) out_valid)
    else $error("result missing after fixed latency");

  a_code_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.code_valid) |-> (out_data.status == rtb_pkg::ST_OK))
    else $error("code marked valid with error status");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.code_valid) |-> (out_data.final_timeout_code_out == 16'd0))
    else $error("code nonzero while not valid");

  a_err_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != rtb_pkg::ST_OK) |-> (out_data.total_us == 32'd0))
    else $error("budget nonzero on error");
`endif

endmodule
`default_nettype wire

FILE: sim/ranging_timing_budget_calc_tb.sv
// Testbench for ranging_timing_budget_calc: directed and random timing register sets,
// checked against an in-bench budget/timeout predictor. Depends on rtb_pkg and the DUT.
`default_nettype none
module ranging_timing_budget_calc_tb;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  rtb_pkg::in_t   in_data;
  logic  out_valid;
  rtb_pkg::out_t  out_data;

  rtb_pkg::out_t  budget_q[$];
  int    errors;
  longint cycles;

  localparam longint CYCLE_LIMIT = 200000;

  ranging_timing_budget_calc i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pulse_macro_ns(input logic [7:0] code);
    logic [31:0] p;
    p = 32'(8'((code + 9'd1) << 1));
    return (32'd2304 * p * 32'd1655 + 32'd500) / 32'd1000;
  endfunction

  function automatic logic [31:0] step_us(input logic [31:0] clks, input logic [31:0] macro);
    return (clks * macro + macro / 32'd2) / 32'd1000;
  endfunction

  function automatic logic [15:0] clocks_of(input logic [15:0] code);
    logic [15:0] v;
    v = (code[15:8] < 8'd16) ? 16'({16'd0, code[7:0]} << code[15:8]) : 16'd0;
    return v + 16'd1;
  endfunction

  function automatic logic [15:0] timeout_code(input logic [15:0] clks);
    logic [31:0] ls;
    logic [7:0]  ms;
    if (clks == 16'd0) return 16'd0;
    ls = 32'(clks) - 32'd1;
    ms = 8'd0;
    while ((ls & 32'hFFFFFF00) != 0) begin
      ls = ls >> 1;
      ms++;
    end
    return {ms, ls[7:0]};
  endfunction

  function automatic rtb_pkg::out_t predict_budget(input rtb_pkg::in_t it);
    rtb_pkg::out_t r;
    logic        tcc, dss, msrc, pre, fin;
    logic [31:0] pm, fm, msrc_us, pre_us, used, left, req;
    logic [15:0] pc, fc, mc;
    tcc = it.sequence_enables[rtb_pkg::SEQ_TCC];
    dss = it.sequence_enables[rtb_pkg::SEQ_DSS];
    msrc = it.sequence_enables[rtb_pkg::SEQ_MSRC];
    pre = it.sequence_enables[rtb_pkg::SEQ_PRE];
    fin = it.sequence_enables[rtb_pkg::SEQ_FINAL];
    req = it.req_total_us;
    pm = pulse_macro_ns(it.pre_period_code);
    fm = pulse_macro_ns(it.final_period_code);
    msrc_us = step_us(32'(it.msrc_timeout_code) + 32'd1, pm);
    pc = clocks_of(it.pre_timeout_code);
    pre_us = step_us(32'(pc), pm);
    fc = clocks_of(it.final_timeout_code_in);
    r = '0;
    if (pre) fc = fc - pc;
    used = (it.mode ? rtb_pkg::SET_START_OH : rtb_pkg::GET_START_OH) + rtb_pkg::END_OH;
    if (tcc) used += msrc_us + rtb_pkg::TCC_OH;
    if (dss) used += 32'd2 * (msrc_us + rtb_pkg::DSS_OH);
    else if (msrc) used += msrc_us + rtb_pkg::MSRC_OH;
    if (pre) used += pre_us + rtb_pkg::PRE_OH;
    if (!it.mode) begin
      if (fin) used += step_us(32'(fc), fm) + rtb_pkg::FINAL_OH;
      r.total_us = used;
    end else if (req < rtb_pkg::MIN_TOTAL_US) begin
      r.status = rtb_pkg::ST_BELOW_MIN;
    end else if (!fin) begin
      r.total_us = req;
    end else begin
      used += rtb_pkg::FINAL_OH;
      if (used > req) r.status = rtb_pkg::ST_OVERHEAD;
      else if (fm == 0) r.status = rtb_pkg::ST_ZERO_PER;
      else begin
        left = req - used;
        mc = 16'((left * 32'd1000 + fm / 32'd2) / fm);
        if (pre) mc = mc + pc;
        r.final_timeout_code_out = timeout_code(mc);
        r.code_valid = 1'b1;
        r.total_us = req;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ranging_timing_budget_calc_tb failed");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (budget_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        rtb_pkg::out_t e;
        e = budget_q.pop_front();
        if (e.total_us !== out_data.total_us) begin
          $display("%0t: total_us exp %h got %h", $time, e.total_us, out_data.total_us);
          errors++;
        end
        if (e.final_timeout_code_out !== out_data.final_timeout_code_out) begin
          $display("%0t: code exp %h got %h", $time, e.final_timeout_code_out,
                   out_data.final_timeout_code_out);
          errors++;
        end
        if (e.code_valid !== out_data.code_valid) begin
          $display("%0t: code_valid exp %b got %b", $time, e.code_valid, out_data.code_valid);
          errors++;
        end
        if (e.status !== out_data.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
          errors++;
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 2) == 0) return;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input rtb_pkg::in_t it, input bit gaps);
    if (gaps) idle_gap();
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    budget_q.push_back(predict_budget(it));
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic rtb_pkg::in_t rand_item();
    rtb_pkg::in_t it;
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(rtb_pkg::in_t)-1:0];
    return it;
  endfunction

  // mostly plausible settings so mode 1 gets through to the encode path
  function automatic rtb_pkg::in_t plausible_item();
    rtb_pkg::in_t it;
    it = rand_item();
    it.pre_period_code = 8'($urandom_range(2, 12));
    it.final_period_code = 8'($urandom_range(2, 10));
    it.msrc_timeout_code = 8'($urandom_range(0, 60));
    it.pre_timeout_code = {8'($urandom_range(0, 3)), 8'($urandom)};
    it.final_timeout_code_in = {8'($urandom_range(0, 9)), 8'($urandom)};
    it.req_total_us = $urandom_range(19000, 400000);
    if ($urandom_range(0, 3) != 0) it.sequence_enables[rtb_pkg::SEQ_FINAL] = 1'b1;
    return it;
  endfunction

  task automatic test_directed();
    rtb_pkg::in_t it;
    it = '0;
    send_item(it, 1'b0);
    it = '1;
    send_item(it, 1'b0);
    it.mode = 1'b0;
    send_item(it, 1'b0);
    // zero periods in both modes
    it = plausible_item();
    it.pre_period_code = 8'd127;
    it.final_period_code = 8'd255;
    it.mode = 1'b0;
    send_item(it, 1'b0);
    it.mode = 1'b1;
    it.sequence_enables[rtb_pkg::SEQ_FINAL] = 1'b1;
    it.req_total_us = 32'd300000;
    send_item(it, 1'b0);
    // below minimum and exactly minimum
    it = plausible_item();
    it.mode = 1'b1;
    it.req_total_us = rtb_pkg::MIN_TOTAL_US - 32'd1;
    send_item(it, 1'b0);
    it.req_total_us = rtb_pkg::MIN_TOTAL_US;
    send_item(it, 1'b0);
    // final range disabled
    it.sequence_enables = 8'h5C;
    it.req_total_us = 32'd33000;
    send_item(it, 1'b0);
    // overheads exceed budget
    it.sequence_enables = 8'hDC;
    it.msrc_timeout_code = 8'd255;
    it.req_total_us = 32'd20000;
    send_item(it, 1'b0);
    // normal fits, with and without pre-range; large request
    it = plausible_item();
    it.mode = 1'b1;
    it.sequence_enables = 8'hD4;
    send_item(it, 1'b0);
    it.sequence_enables = 8'h84;
    it.req_total_us = 32'hFFFFFFFF;
    send_item(it, 1'b0);
    // ignored bits only, and shift of 16 or more
    it = plausible_item();
    it.mode = 1'b0;
    it.sequence_enables = 8'h23;
    send_item(it, 1'b0);
    it.sequence_enables = 8'hFF;
    it.pre_timeout_code = 16'h10FF;
    it.final_timeout_code_in = 16'hFF80;
    send_item(it, 1'b0);
    it.pre_timeout_code = 16'h0FFF;
    it.final_timeout_code_in = 16'h0F01;
    send_item(it, 1'b0);
    // period codes in mode 0 swept coarsely, in steps of 37
    for (int c = 0; c < 256; c += 37) begin
      it = plausible_item();
      it.mode = 1'b0;
      it.pre_period_code = 8'(c);
      it.final_period_code = 8'(255 - c);
      send_item(it, 1'b0);
    end
    stop_sending();
  endtask

  task automatic test_random();
    for (int i = 0; i < 520; i++) begin
      if (i == 300) begin
        stop_sending();
        while (budget_q.size() != 0) @(posedge clk);
      end
      send_item(($urandom_range(0, 4) == 0) ? rand_item() : plausible_item(), 1'b1);
      if (i % 100 == 50) begin
        for (int k = 0; k < 20; k++) send_item(plausible_item(), 1'b0);
      end
    end
    stop_sending();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    while (budget_q.size() != 0) @(posedge clk);
    repeat (rtb_pkg::LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("ranging_timing_budget_calc_tb passed");
    end else begin
      $display("ranging_timing_budget_calc_tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
